// ===== design/abfu_pkg.sv =====
// Shared types, codes and the blend factor function of the ARGB blend factor unit.
package abfu_pkg;

  localparam int ChanW = 8;
  localparam int ProdW = 2 * ChanW;
  localparam int NumChan = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Blend factor codes.
  localparam logic [3:0] FAC_ZERO       = 4'd0;
  localparam logic [3:0] FAC_ONE        = 4'd1;
  localparam logic [3:0] FAC_SRC_A      = 4'd2;
  localparam logic [3:0] FAC_INV_SRC_A  = 4'd3;
  localparam logic [3:0] FAC_DST_A      = 4'd4;
  localparam logic [3:0] FAC_INV_DST_A  = 4'd5;
  localparam logic [3:0] FAC_SRC_C      = 4'd6;
  localparam logic [3:0] FAC_DST_C      = 4'd7;
  localparam logic [3:0] FAC_INV_SRC_C  = 4'd8;
  localparam logic [3:0] FAC_INV_DST_C  = 4'd9;

  // Blend operation codes.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_SUB     = 2'd1;
  localparam logic [1:0] OP_REV_SUB = 2'd2;
  localparam logic [1:0] OP_KEEP    = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SRC_FACTOR = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DST_FACTOR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BLEND_OP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TINT_EN    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TINT_COLOR = 3'd4;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [ProdW-1:0] prod_t;

  typedef struct packed {
    logic [3:0]  src_factor;
    logic [3:0]  dst_factor;
    logic [1:0]  op;
    logic        tint_en;
    logic [31:0] tint_color;
  } cfg_t;

  // Word after the tint stage.
  typedef struct packed {
    logic                   vld;
    logic                   pass;
    logic                   row_last;
    chan_t                  sa;
    chan_t [NumChan-1:0]    sc;
    chan_t                  da;
    chan_t [NumChan-1:0]    dc;
  } s1_t;

  // Word after the weighting stage.
  typedef struct packed {
    logic                   vld;
    logic                   pass;
    logic                   row_last;
    chan_t                  alpha;
    chan_t                  da;
    prod_t [NumChan-1:0]    ps;
    prod_t [NumChan-1:0]    pd;
    chan_t [NumChan-1:0]    dc;
  } s2_t;

  function automatic chan_t pick_factor(input logic [3:0] sel, input chan_t sa,
                                        input chan_t sc, input chan_t da,
                                        input chan_t dc);
    chan_t f;
    case (sel)
      FAC_ZERO:      f = '0;
      FAC_ONE:       f = ChanMax;
      FAC_SRC_A:     f = sa;
      FAC_INV_SRC_A: f = ChanMax - sa;
      FAC_DST_A:     f = da;
      FAC_INV_DST_A: f = ChanMax - da;
      FAC_SRC_C:     f = sc;
      FAC_DST_C:     f = dc;
      FAC_INV_SRC_C: f = ChanMax - sc;
      FAC_INV_DST_C: f = ChanMax - dc;
      default:       f = ChanMax;
    endcase
    return f;
  endfunction

endpackage

// ===== design/abfu_tint.sv =====
// First pipeline stage: transparency check and optional tint multiply of the source.
module abfu_tint (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   acc,
  input  abfu_pkg::cfg_t                         cfg,
  input  abfu_pkg::chan_t                        sa,
  input  abfu_pkg::chan_t [abfu_pkg::NumChan-1:0] sc,
  input  abfu_pkg::chan_t                        da,
  input  abfu_pkg::chan_t [abfu_pkg::NumChan-1:0] dc,
  input  logic                                   row_last,
  output abfu_pkg::s1_t                          s1
);
  import abfu_pkg::*;

  s1_t   s1_r;
  s1_t   s1_nxt;
  logic  tint_on;
  chan_t tint_a;
  chan_t [NumChan-1:0] tint_c;
  prod_t [NumChan-1:0] c_prod;
  prod_t a_prod;

  assign tint_a    = cfg.tint_color[31:24];
  assign tint_c[0] = cfg.tint_color[23:16];
  assign tint_c[1] = cfg.tint_color[15:8];
  assign tint_c[2] = cfg.tint_color[7:0];
  assign tint_on   = cfg.tint_en && (tint_a != '0);

  always_comb begin
    a_prod = ProdW'(sa) * ProdW'(tint_a);
    for (int i = 0; i < NumChan; i++) begin
      c_prod[i] = ProdW'(sc[i]) * ProdW'(tint_c[i]);
    end
    s1_nxt          = s1_r;
    s1_nxt.vld      = acc;
    s1_nxt.pass     = (sa == '0);
    s1_nxt.row_last = row_last;
    s1_nxt.da       = da;
    s1_nxt.dc       = dc;
    if (tint_on) begin
      s1_nxt.sa = a_prod[ProdW-1:ChanW];
      for (int i = 0; i < NumChan; i++) begin
        s1_nxt.sc[i] = c_prod[i][ProdW-1:ChanW];
      end
    end else begin
      s1_nxt.sa = sa;
      s1_nxt.sc = sc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// ===== design/abfu_weight.sv =====
// Second pipeline stage: factor selection and the source and destination products.
module abfu_weight (
  input  logic           clk,
  input  logic           rst_n,
  input  abfu_pkg::cfg_t cfg,
  input  abfu_pkg::s1_t  s1,
  output abfu_pkg::s2_t  s2
);
  import abfu_pkg::*;

  s2_t   s2_r;
  s2_t   s2_nxt;
  chan_t [NumChan-1:0] fs;
  chan_t [NumChan-1:0] fd;

  always_comb begin
    s2_nxt          = s2_r;
    s2_nxt.vld      = s1.vld;
    s2_nxt.pass     = s1.pass;
    s2_nxt.row_last = s1.row_last;
    s2_nxt.da       = s1.da;
    s2_nxt.dc       = s1.dc;
    s2_nxt.alpha    = (s1.sa > s1.da) ? s1.sa : s1.da;
    for (int i = 0; i < NumChan; i++) begin
      fs[i] = pick_factor(cfg.src_factor, s1.sa, s1.sc[i], s1.da, s1.dc[i]);
      fd[i] = pick_factor(cfg.dst_factor, s1.sa, s1.sc[i], s1.da, s1.dc[i]);
      s2_nxt.ps[i] = ProdW'(s1.sc[i]) * ProdW'(fs[i]);
      s2_nxt.pd[i] = ProdW'(s1.dc[i]) * ProdW'(fd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

// ===== design/abfu_combine.sv =====
// Third pipeline stage: blend operation, pass-through selection and the result register.
module abfu_combine (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  abfu_pkg::cfg_t                          cfg,
  input  abfu_pkg::s2_t                           s2,
  output logic                                    res_vld,
  output abfu_pkg::chan_t                         res_alpha,
  output abfu_pkg::chan_t [abfu_pkg::NumChan-1:0] res_chan,
  output logic                                    res_written,
  output logic                                    res_row_last
);
  import abfu_pkg::*;

  logic  vld_r;
  chan_t alpha_r;
  chan_t alpha_nxt;
  chan_t [NumChan-1:0] chan_r;
  chan_t [NumChan-1:0] chan_nxt;
  logic  written_r;
  logic  row_last_r;
  prod_t sum;
  prod_t diff;

  always_comb begin
    alpha_nxt = s2.pass ? s2.da : s2.alpha;
    for (int i = 0; i < NumChan; i++) begin
      // Only bits 15:8 of the sum are kept, so the carry out is not needed.
      sum  = s2.ps[i] + s2.pd[i];
      diff = '0;
      unique case (cfg.op)
        OP_ADD: begin
          chan_nxt[i] = sum[ProdW-1:ChanW];
        end
        OP_SUB: begin
          // Any negative difference floors to zero; a 16-bit difference
          // shifted by eight never exceeds full scale.
          if (s2.ps[i] >= s2.pd[i]) begin
            diff = s2.ps[i] - s2.pd[i];
          end
          chan_nxt[i] = diff[ProdW-1:ChanW];
        end
        OP_REV_SUB: begin
          if (s2.pd[i] >= s2.ps[i]) begin
            diff = s2.pd[i] - s2.ps[i];
          end
          chan_nxt[i] = diff[ProdW-1:ChanW];
        end
        OP_KEEP: begin
          chan_nxt[i] = s2.dc[i];
        end
      endcase
      if (s2.pass) begin
        chan_nxt[i] = s2.dc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s2.vld;
    end
    alpha_r    <= alpha_nxt;
    chan_r     <= chan_nxt;
    written_r  <= !s2.pass;
    row_last_r <= s2.row_last;
  end

  assign res_vld      = vld_r;
  assign res_alpha    = alpha_r;
  assign res_chan     = chan_r;
  assign res_written  = written_r;
  assign res_row_last = row_last_r;

endmodule

// ===== design/argb_blend_factor_unit_top.sv =====
// Top level of the ARGB blend factor unit: configuration registers and the blend pipeline.
//
// This unit blends one source and one destination ARGB8888 pixel per clock. A word is
// taken whenever start is high; busy is held low at all times, so a new pixel may be
// presented in every cycle. Each word yields exactly one result, shown on the out_
// ports for a single cycle with out_valid high. The receiver cannot hold results off
// and must take every strobed result. The pipeline has three register stages: the tint
// multiply, the factor multiply, and the result register after the blend operation. A
// source pixel with zero alpha passes the destination through with out_written low.
// Configuration is written through the cfg_ channel, which is always ready; it should
// only be changed while no pixel is in flight.
module argb_blend_factor_unit_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_src_alpha,
  input  logic [7:0]                    in_src_red,
  input  logic [7:0]                    in_src_green,
  input  logic [7:0]                    in_src_blue,
  input  logic [7:0]                    in_dst_alpha,
  input  logic [7:0]                    in_dst_red,
  input  logic [7:0]                    in_dst_green,
  input  logic [7:0]                    in_dst_blue,
  input  logic                          in_row_last,
  output logic                          out_valid,
  output logic [7:0]                    out_alpha,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic                          out_written,
  output logic                          out_row_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [abfu_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [abfu_pkg::CfgDataW-1:0] cfg_data
);
  import abfu_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  acc;
  s1_t   s1;
  s2_t   s2;
  chan_t [NumChan-1:0] src_c;
  chan_t [NumChan-1:0] dst_c;
  chan_t [NumChan-1:0] res_c;

  // The pipeline never stalls, so the unit is never busy and the
  // configuration channel is always ready.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_FACTOR: cfg_nxt.src_factor = cfg_data[3:0];
        REG_DST_FACTOR: cfg_nxt.dst_factor = cfg_data[3:0];
        REG_BLEND_OP:   cfg_nxt.op         = cfg_data[1:0];
        REG_TINT_EN:    cfg_nxt.tint_en    = cfg_data[0];
        REG_TINT_COLOR: cfg_nxt.tint_color = cfg_data;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_factor <= FAC_SRC_A;
      cfg_r.dst_factor <= FAC_INV_SRC_A;
      cfg_r.op         <= OP_ADD;
      cfg_r.tint_en    <= 1'b0;
      cfg_r.tint_color <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign src_c = {in_src_blue, in_src_green, in_src_red};
  assign dst_c = {in_dst_blue, in_dst_green, in_dst_red};

  abfu_tint u_tint (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .cfg      (cfg_r),
    .sa       (in_src_alpha),
    .sc       (src_c),
    .da       (in_dst_alpha),
    .dc       (dst_c),
    .row_last (in_row_last),
    .s1       (s1)
  );

  abfu_weight u_weight (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .s1    (s1),
    .s2    (s2)
  );

  abfu_combine u_combine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .s2           (s2),
    .res_vld      (out_valid),
    .res_alpha    (out_alpha),
    .res_chan     (res_c),
    .res_written  (out_written),
    .res_row_last (out_row_last)
  );

  assign out_red   = res_c[0];
  assign out_green = res_c[1];
  assign out_blue  = res_c[2];

  // Every accepted word produces a valid result on the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##3 out_valid)
    else $error("accepted word did not produce a result after three cycles");

  // A pass-through result carries the destination alpha of its own word.
  a_pass_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_written) |-> (out_alpha == $past(in_dst_alpha, 3)))
    else $error("pass-through alpha does not match the destination");

  // A blended alpha is the maximum, so it never falls below the destination alpha.
  a_blend_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_written) |-> (out_alpha >= $past(in_dst_alpha, 3)))
    else $error("blended alpha below destination alpha");

  // The row marker travels with its word.
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_last == $past(in_row_last, 3)))
    else $error("row marker lost its word");

endmodule

// ===== tb/abfu_blend_checker.sv =====
// Checker for the ARGB blend factor unit: mirrors the registers, predicts each pixel, compares.
`timescale 1ns / 1ps
module abfu_blend_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [7:0]                    in_src_alpha,
  input  logic [7:0]                    in_src_red,
  input  logic [7:0]                    in_src_green,
  input  logic [7:0]                    in_src_blue,
  input  logic [7:0]                    in_dst_alpha,
  input  logic [7:0]                    in_dst_red,
  input  logic [7:0]                    in_dst_green,
  input  logic [7:0]                    in_dst_blue,
  input  logic                          in_row_last,
  input  logic                          out_valid,
  input  logic [7:0]                    out_alpha,
  input  logic [7:0]                    out_red,
  input  logic [7:0]                    out_green,
  input  logic [7:0]                    out_blue,
  input  logic                          out_written,
  input  logic                          out_row_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [abfu_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [abfu_pkg::CfgDataW-1:0] cfg_data,
  output int                            mismatch_count,
  output int                            pixels_in_flight
);
  import abfu_pkg::*;

  typedef struct packed {
    chan_t               sa;
    chan_t [NumChan-1:0] sc;
    chan_t               da;
    chan_t [NumChan-1:0] dc;
    logic                row_last;
  } pixel_pair_t;

  typedef struct packed {
    chan_t alpha;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  written;
    logic  row_last;
  } blended_pixel_t;

  logic [3:0]  mir_src_factor;
  logic [3:0]  mir_dst_factor;
  logic [1:0]  mir_op;
  logic        mir_tint_en;
  logic [31:0] mir_tint_color;

  blended_pixel_t expected_pixels[$];

  function automatic chan_t factor_weight(input logic [3:0] sel, input chan_t sa,
                                          input chan_t sc, input chan_t da,
                                          input chan_t dc);
    case (sel)
      FAC_ZERO:      return 8'd0;
      FAC_ONE:       return 8'd255;
      FAC_SRC_A:     return sa;
      FAC_INV_SRC_A: return 8'd255 - sa;
      FAC_DST_A:     return da;
      FAC_INV_DST_A: return 8'd255 - da;
      FAC_SRC_C:     return sc;
      FAC_DST_C:     return dc;
      FAC_INV_SRC_C: return 8'd255 - sc;
      FAC_INV_DST_C: return 8'd255 - dc;
      default:       return 8'd255;
    endcase
  endfunction

  // Difference shifted down by eight; a negative difference gives zero.
  function automatic chan_t floor_diff(input prod_t a, input prod_t b);
    prod_t d;
    if (a < b) return 8'd0;
    d = a - b;
    return d[15:8];
  endfunction

  function automatic blended_pixel_t blend_pixel(input pixel_pair_t px);
    chan_t               sa;
    chan_t [NumChan-1:0] sc;
    chan_t [NumChan-1:0] res;
    chan_t               tint_a;
    chan_t               fs;
    chan_t               fd;
    prod_t               ps;
    prod_t               pd;
    prod_t               scaled;
    prod_t               sum;
    blended_pixel_t      r;
    r.row_last = px.row_last;
    // A fully transparent source leaves the destination untouched.
    if (px.sa == 8'd0) begin
      r.alpha   = px.da;
      r.red     = px.dc[0];
      r.green   = px.dc[1];
      r.blue    = px.dc[2];
      r.written = 1'b0;
      return r;
    end
    sa = px.sa;
    sc = px.sc;
    tint_a = mir_tint_en ? mir_tint_color[31:24] : 8'd0;
    if (tint_a != 8'd0) begin
      for (int i = 0; i < NumChan; i++) begin
        scaled = 16'(sc[i]) * 16'(mir_tint_color[16-8*i +: 8]);
        sc[i] = scaled[15:8];
      end
      scaled = 16'(sa) * 16'(tint_a);
      sa = scaled[15:8];
    end
    for (int i = 0; i < NumChan; i++) begin
      fs = factor_weight(mir_src_factor, sa, sc[i], px.da, px.dc[i]);
      fd = factor_weight(mir_dst_factor, sa, sc[i], px.da, px.dc[i]);
      ps = 16'(sc[i]) * 16'(fs);
      pd = 16'(px.dc[i]) * 16'(fd);
      case (mir_op)
        OP_ADD: begin
          // The carry out of the sum is dropped along with everything above bit 15.
          sum = ps + pd;
          res[i] = sum[15:8];
        end
        OP_SUB:     res[i] = floor_diff(ps, pd);
        OP_REV_SUB: res[i] = floor_diff(pd, ps);
        default:    res[i] = px.dc[i];
      endcase
    end
    r.alpha   = (sa > px.da) ? sa : px.da;
    r.red     = res[0];
    r.green   = res[1];
    r.blue    = res[2];
    r.written = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_pair_t    px;
    blended_pixel_t want;
    blended_pixel_t got;
    if (!rst_n) begin
      mir_src_factor = FAC_SRC_A;
      mir_dst_factor = FAC_INV_SRC_A;
      mir_op         = OP_ADD;
      mir_tint_en    = 1'b0;
      mir_tint_color = 32'd0;
      mismatch_count = 0;
      expected_pixels.delete();
    end else begin
      if (out_valid) begin
        got = '{out_alpha, out_red, out_green, out_blue, out_written, out_row_last};
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result a=%02h r=%02h g=%02h b=%02h w=%0b last=%0b",
                     $time, got.alpha, got.red, got.green, got.blue, got.written,
                     got.row_last);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch: expected a=%02h r=%02h g=%02h b=%02h w=%0b last=%0b",
                       $time, want.alpha, want.red, want.green, want.blue, want.written,
                       want.row_last);
              $display("%0t:                got a=%02h r=%02h g=%02h b=%02h w=%0b last=%0b",
                       $time, got.alpha, got.red, got.green, got.blue, got.written,
                       got.row_last);
            end
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        px.sa       = in_src_alpha;
        px.sc       = {in_src_blue, in_src_green, in_src_red};
        px.da       = in_dst_alpha;
        px.dc       = {in_dst_blue, in_dst_green, in_dst_red};
        px.row_last = in_row_last;
        expected_pixels.push_back(blend_pixel(px));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_FACTOR: mir_src_factor = cfg_data[3:0];
          REG_DST_FACTOR: mir_dst_factor = cfg_data[3:0];
          REG_BLEND_OP:   mir_op         = cfg_data[1:0];
          REG_TINT_EN:    mir_tint_en    = cfg_data[0];
          REG_TINT_COLOR: mir_tint_color = cfg_data;
          default: ;
        endcase
      end
    end
    pixels_in_flight = expected_pixels.size();
  end

endmodule

// ===== tb/argb_blend_factor_unit_top_tb.sv =====
// Testbench top for the ARGB blend factor unit: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 1ps
module argb_blend_factor_unit_top_tb;
  import abfu_pkg::*;

  // Generous bound on the whole run.
  localparam int CycleLimit = 200000;
  // Three register stages inside the block, plus a little margin.
  localparam int DrainCycles = 6;
  localparam int RandomPhases = 12;
  localparam int WordsPerPhase = 125;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [7:0]          in_src_alpha = '0;
  logic [7:0]          in_src_red = '0;
  logic [7:0]          in_src_green = '0;
  logic [7:0]          in_src_blue = '0;
  logic [7:0]          in_dst_alpha = '0;
  logic [7:0]          in_dst_red = '0;
  logic [7:0]          in_dst_green = '0;
  logic [7:0]          in_dst_blue = '0;
  logic                in_row_last = 1'b0;
  logic                out_valid;
  logic [7:0]          out_alpha;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic                out_written;
  logic                out_row_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  mismatch_count;
  int                  pixels_in_flight;
  int                  cycle_count;

  // 12 ns period: high for half, low for half.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  argb_blend_factor_unit_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_src_alpha (in_src_alpha),
    .in_src_red   (in_src_red),
    .in_src_green (in_src_green),
    .in_src_blue  (in_src_blue),
    .in_dst_alpha (in_dst_alpha),
    .in_dst_red   (in_dst_red),
    .in_dst_green (in_dst_green),
    .in_dst_blue  (in_dst_blue),
    .in_row_last  (in_row_last),
    .out_valid    (out_valid),
    .out_alpha    (out_alpha),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_written  (out_written),
    .out_row_last (out_row_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // The checker sits beside the block, watches every channel and keeps its own count of
  // failures; this module only makes stimulus and delivers the verdict.
  abfu_blend_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_src_alpha     (in_src_alpha),
    .in_src_red       (in_src_red),
    .in_src_green     (in_src_green),
    .in_src_blue      (in_src_blue),
    .in_dst_alpha     (in_dst_alpha),
    .in_dst_red       (in_dst_red),
    .in_dst_green     (in_dst_green),
    .in_dst_blue      (in_dst_blue),
    .in_row_last      (in_row_last),
    .out_valid        (out_valid),
    .out_alpha        (out_alpha),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_written      (out_written),
    .out_row_last     (out_row_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // Watchdog: if the run has not finished by the limit, something has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[argb_blend_factor_unit_top] ERROR");
    $finish;
  end

  // Channel values with the extremes weighted up, so that saturation, wrap-round and
  // the transparent source turn up often.
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one pixel word at the falling edge and hold it until the block takes it.
  // Start is left high afterwards, so a following word continues without a bubble.
  task automatic push_pixel(input chan_t sa, input chan_t sr, input chan_t sg,
                            input chan_t sb, input chan_t da, input chan_t dr,
                            input chan_t dg, input chan_t db, input logic rl);
    @(negedge clk);
    start        = 1'b1;
    in_src_alpha = sa;
    in_src_red   = sr;
    in_src_green = sg;
    in_src_blue  = sb;
    in_dst_alpha = da;
    in_dst_red   = dr;
    in_dst_green = dg;
    in_dst_blue  = db;
    in_row_last  = rl;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic push_random_pixel();
    push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
               rand_chan(), rand_chan(), rand_chan(), 1'($urandom_range(0, 1)));
  endtask

  // Idle cycles with start low; the data ports carry noise the block must ignore.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start        = 1'b0;
      in_src_alpha = rand_chan();
      in_src_red   = rand_chan();
      in_src_green = rand_chan();
      in_src_blue  = rand_chan();
      in_dst_alpha = rand_chan();
      in_dst_red   = rand_chan();
      in_dst_green = rand_chan();
      in_dst_blue  = rand_chan();
      in_row_last  = 1'($urandom_range(0, 1));
    end
  endtask

  // Stop issuing words and wait until every predicted result has come back, then let the
  // pipeline run empty for the DrainCycles margin.
  task automatic drain_pipeline();
    @(negedge clk);
    start = 1'b0;
    while (pixels_in_flight != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Random upper bits on narrow registers check that only the register's own bits count.
  function automatic logic [31:0] with_junk(input logic [31:0] value, input logic [31:0] mask);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
    return (junk & ~mask) | (value & mask);
  endfunction

  // Rewrite the whole register set once the block is idle.
  task automatic program_blend(input logic [3:0] sf, input logic [3:0] df,
                               input logic [1:0] op, input logic te,
                               input logic [31:0] tc);
    drain_pipeline();
    write_reg(REG_SRC_FACTOR, with_junk(32'(sf), 32'hF));
    write_reg(REG_DST_FACTOR, with_junk(32'(df), 32'hF));
    write_reg(REG_BLEND_OP,   with_junk(32'(op), 32'h3));
    write_reg(REG_TINT_EN,    with_junk(32'(te), 32'h1));
    write_reg(REG_TINT_COLOR, tc);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = $urandom();
  endtask

  function automatic logic [31:0] rand_tint();
    case ($urandom_range(0, 3))
      0:       return {8'd0, 24'($urandom())};
      1:       return {8'd255, 24'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int burst_left;
    int gap;

    // Synchronous reset held from time zero and released at a falling edge.
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed words under the reset settings: source alpha over inverse source alpha.
    // The transparent source must hand the destination back unwritten.
    push_pixel(8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd0, 8'd12, 8'd34, 8'd56, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd1, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);

    // One plus one on full-scale channels overflows, and the carry out of the 16-bit sum is dropped.
    program_blend(FAC_ONE, FAC_ONE, OP_ADD, 1'b0, 32'd0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd128, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 1'b0);

    // Subtraction with a positive, a zero and a negative difference across the channels.
    program_blend(FAC_ONE, FAC_ONE, OP_SUB, 1'b0, 32'd0);
    push_pixel(8'd255, 8'd200, 8'd100, 8'd0, 8'd255, 8'd100, 8'd100, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);

    program_blend(FAC_ONE, FAC_ONE, OP_REV_SUB, 1'b0, 32'd0);
    push_pixel(8'd255, 8'd200, 8'd100, 8'd0, 8'd255, 8'd100, 8'd100, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);

    // Keep destination: colours are the destination's, alpha is still the larger one.
    program_blend(FAC_SRC_C, FAC_DST_C, OP_KEEP, 1'b0, 32'd0);
    push_pixel(8'd200, 8'd1, 8'd2, 8'd3, 8'd50, 8'd9, 8'd8, 8'd7, 1'b1);
    push_pixel(8'd10, 8'd1, 8'd2, 8'd3, 8'd250, 8'd9, 8'd8, 8'd7, 1'b0);

    // Full tint; transparency is judged before the tint is applied.
    program_blend(FAC_SRC_C, FAC_INV_DST_C, OP_ADD, 1'b1, 32'hFFFF_FFFF);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd100, 8'd100, 8'd100, 8'd100, 1'b0);
    push_pixel(8'd0, 8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 1'b1);

    // A faint tint pushes a small source alpha down to zero, yet the pixel is written.
    program_blend(FAC_DST_A, FAC_INV_DST_A, OP_ADD, 1'b1, 32'h0180_4020);
    push_pixel(8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd10, 8'd20, 8'd30, 1'b0);
    push_pixel(8'd255, 8'd128, 8'd64, 8'd32, 8'd0, 8'd200, 8'd200, 8'd200, 1'b1);

    // Tint enabled but with zero tint alpha leaves the source alone.
    program_blend(FAC_INV_SRC_C, FAC_SRC_A, OP_ADD, 1'b1, 32'h00FF_00FF);
    push_pixel(8'd200, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 1'b0);

    // Factor codes above the defined set behave as one; tint colour set but disabled.
    program_blend(4'd10, 4'd15, OP_ADD, 1'b0, 32'h8040_2010);
    push_pixel(8'd77, 8'd255, 8'd1, 8'd128, 8'd99, 8'd3, 8'd200, 8'd17, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);

    // Random phases. The first two pin every register at its lowest and highest value;
    // the rest draw fresh settings. Within a phase the words come in bursts separated by
    // random gaps, some bursts running straight into the next with no gap at all.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       program_blend(FAC_ZERO, FAC_ZERO, OP_ADD, 1'b0, 32'd0);
        1:       program_blend(4'd15, 4'd15, OP_KEEP, 1'b1, 32'hFFFF_FFFF);
        default: program_blend(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               rand_tint());
      endcase
      // A write to an unused index must change nothing.
      if (phase == 3) begin
        write_reg(CfgIdxW'(REG_TINT_COLOR + $urandom_range(1, 3)), $urandom());
        @(negedge clk);
        cfg_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < WordsPerPhase; n++) begin
        push_random_pixel();
        burst_left--;
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          idle_cycles(gap);
          burst_left = $urandom_range(1, 40);
        end
      end
    end

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("[argb_blend_factor_unit_top] OK");
    end else begin
      $display("[argb_blend_factor_unit_top] ERROR");
    end
    $finish;
  end

endmodule
